/* rtl/bsvf_pkg.sv */
// ----------------------------------------------------------------------------
// bsvf_pkg
// Shared widths, constants and control types of the supply voltage filter.
// ----------------------------------------------------------------------------
package bsvf_pkg;

    localparam int CODE_W  = 12;
    localparam int NUM_W   = 20;
    localparam int SHIFT_W = 4;
    localparam int VDD_W   = 11;
    localparam int Q5_W    = 16;
    localparam int DVD_W   = NUM_W + 1;
    localparam int CFG_IDX_W = 1;

    localparam logic [NUM_W-1:0]   NUM_RESET   = 20'd419430;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd3;
    localparam logic [VDD_W-1:0]   VDD_LIMIT   = 11'd2000;
    localparam logic [Q5_W:0]      Q5_HALF     = 17'd16;

    localparam logic [CFG_IDX_W-1:0] REG_NUMERATOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT     = 1'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

/* rtl/bsvf_if.sv */
// ----------------------------------------------------------------------------
// bsvf_if
// Valid/ready channels of the supply voltage filter.
// ----------------------------------------------------------------------------
interface bsvf_in_if;
    logic                        valid;
    logic                        ready;
    logic [bsvf_pkg::CODE_W-1:0] adc_code;

    modport source (output valid, output adc_code, input ready);
    modport sink   (input valid, input adc_code, output ready);
endinterface

interface bsvf_out_if;
    logic                       valid;
    logic                       ready;
    logic [bsvf_pkg::VDD_W-1:0] supply_centivolts;

    modport source (output valid, output supply_centivolts, input ready);
    modport sink   (input valid, input supply_centivolts, output ready);
endinterface

interface bsvf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bsvf_pkg::CFG_IDX_W-1:0] index;
    logic [bsvf_pkg::NUM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/bsvf_div.sv */
// ----------------------------------------------------------------------------
// bsvf_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsvf_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [bsvf_pkg::DVD_W-1:0]   i_dividend,
    input  logic [bsvf_pkg::CODE_W-1:0]  i_divisor,
    output logic [bsvf_pkg::DVD_W-1:0]   o_quot,
    output bsvf_pkg::t_unit_stat         o_stat
);
    import bsvf_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic [CODE_W-1:0] r_rem, n_rem;
    logic [DVD_W-1:0]  r_dvd, n_dvd;
    logic [CODE_W-1:0] r_dsr, n_dsr;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CODE_W:0]   trial;
    logic              fits;

    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign fits  = trial >= {1'b0, r_dsr};

    always_comb begin
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
            n_cnt  = CNT_W'(DVD_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = fits ? CODE_W'(trial - {1'b0, r_dsr}) : trial[CODE_W-1:0];
            n_dvd = {r_dvd[DVD_W-2:0], fits};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_cnt <= n_cnt;
    end

    assign o_quot      = r_dvd;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

/* rtl/bsvf_filt.sv */
// ----------------------------------------------------------------------------
// bsvf_filt
// Exponential filter state with a serial right shift of the error.
// ----------------------------------------------------------------------------
module bsvf_filt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bsvf_pkg::VDD_W-1:0]    i_vdd,
    input  logic [bsvf_pkg::SHIFT_W-1:0]  i_shift,
    output logic [bsvf_pkg::Q5_W-1:0]     o_state,
    output bsvf_pkg::t_unit_stat          o_stat
);
    import bsvf_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE  = 2'b01,
        F_SHIFT = 2'b10
    } t_fstate;

    t_fstate            r_fsm, n_fsm;
    logic [Q5_W-1:0]    r_q5, n_q5;
    logic [Q5_W-1:0]    r_diff, n_diff;
    logic               r_up, n_up;
    logic [SHIFT_W-1:0] r_cnt, n_cnt;
    logic               r_done, n_done;
    logic [Q5_W-1:0]    target;

    assign target = {i_vdd, 5'd0};

    always_comb begin
        n_fsm  = r_fsm;
        n_q5   = r_q5;
        n_diff = r_diff;
        n_up   = r_up;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        unique case (r_fsm)
            F_IDLE: begin
                if (i_start) begin
                    if (r_q5 == '0) begin
                        n_q5   = target;
                        n_done = 1'b1;
                    end else begin
                        n_up   = target > r_q5;
                        n_diff = (target > r_q5) ? target - r_q5 : r_q5 - target;
                        n_cnt  = i_shift;
                        n_fsm  = F_SHIFT;
                    end
                end
            end
            F_SHIFT: begin
                if (r_cnt == '0) begin
                    n_q5   = r_up ? r_q5 + r_diff : r_q5 - r_diff;
                    n_done = 1'b1;
                    n_fsm  = F_IDLE;
                end else begin
                    n_diff = {1'b0, r_diff[Q5_W-1:1]};
                    n_cnt  = r_cnt - 1'b1;
                end
            end
            default: n_fsm = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm  <= F_IDLE;
            r_q5   <= '0;
            r_done <= 1'b0;
        end else begin
            r_fsm  <= n_fsm;
            r_q5   <= n_q5;
            r_done <= n_done;
        end
        r_diff <= n_diff;
        r_up   <= n_up;
        r_cnt  <= n_cnt;
    end

    assign o_state     = r_q5;
    assign o_stat.busy = (r_fsm == F_SHIFT);
    assign o_stat.done = r_done;

endmodule

/* rtl/bandgap_supply_voltage_filter.sv */
// ----------------------------------------------------------------------------
// bandgap_supply_voltage_filter
// Band gap reading to filtered supply voltage in hundredths of a volt.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    adc_code[11:0]
//  o_out    out  valid/ready    supply_centivolts[10:0]
//  i_cfg    in   valid/ready    index[0], data[19:0] (ready always high)
//
//  A nonzero reading passes through the bit-serial divider and then the filter,
//  which shifts the error right by filter_shift bits (a reading that seeds the
//  filter skips the shift). A zero reading skips both and gives a zero result.
//  Reset clears the filter state and loads the register defaults.
//  One reading at a time; the next one is taken while a result waits on o_out.
// ----------------------------------------------------------------------------
module bandgap_supply_voltage_filter (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bsvf_in_if.sink     i_in,
    bsvf_out_if.source  o_out,
    bsvf_cfg_if.sink    i_cfg
);
    import bsvf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_FILT = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [NUM_W-1:0]   r_num;
    logic [SHIFT_W-1:0] r_shift;
    logic [VDD_W-1:0]   r_res, n_res;
    logic               r_ovalid, n_ovalid;
    logic [VDD_W-1:0]   r_odata, n_odata;

    logic               in_xfer;
    logic               div_start;
    logic               filt_start;
    logic [DVD_W-1:0]   dividend;
    logic [DVD_W-1:0]   quot;
    logic [VDD_W-1:0]   vdd;
    logic [Q5_W-1:0]    q5;
    logic [Q5_W:0]      q5_round;
    t_unit_stat         div_stat;
    t_unit_stat         filt_stat;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in.valid && i_in.ready;

    assign dividend   = {1'b0, r_num} + {{(DVD_W-CODE_W+1){1'b0}}, i_in.adc_code[CODE_W-1:1]};
    assign div_start  = in_xfer && (i_in.adc_code != '0);
    assign vdd        = (quot > {{(DVD_W-VDD_W){1'b0}}, VDD_LIMIT}) ? VDD_LIMIT
                                                                     : quot[VDD_W-1:0];
    assign filt_start = (r_state == S_DIV) && div_stat.done;
    assign q5_round   = {1'b0, q5} + Q5_HALF;

    bsvf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (i_in.adc_code),
        .o_quot     (quot),
        .o_stat     (div_stat)
    );

    bsvf_filt u_filt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (filt_start),
        .i_vdd   (vdd),
        .i_shift (r_shift),
        .o_state (q5),
        .o_stat  (filt_stat)
    );

    always_comb begin
        n_state  = r_state;
        n_res    = r_res;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        if (o_out.ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in.adc_code == '0) begin
                        n_res   = '0;
                        n_state = S_HOLD;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_FILT;
                end
            end
            S_FILT: begin
                if (filt_stat.done && !filt_stat.busy) begin
                    n_res   = q5_round[VDD_W+4:5];
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_num    <= NUM_RESET;
            r_shift  <= SHIFT_RESET;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    REG_NUMERATOR: r_num   <= i_cfg.data;
                    REG_SHIFT:     r_shift <= i_cfg.data[SHIFT_W-1:0];
                    default: ;
                endcase
            end
        end
        r_res   <= n_res;
        r_odata <= n_odata;
    end

    assign o_out.valid             = r_ovalid;
    assign o_out.supply_centivolts = r_odata;

endmodule
